>>> rtl/spsv_pkg.sv
// ----------------------------------------------------------------------------
// Segmented prime sieve package
// Shared constants, codes, types and the live-bit mask helper for the block.
// ----------------------------------------------------------------------------
package spsv_pkg;

  localparam int SIEVE_BITS = 4096;
  localparam int WORD_BITS  = 64;
  localparam int WORD_COUNT = SIEVE_BITS / WORD_BITS;
  localparam int ADDR_W     = $clog2(WORD_COUNT);
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int IDX_W      = ADDR_W + BIT_W;

  localparam int GROUP_W    = 8;
  localparam int BYTE_COUNT = WORD_BITS / GROUP_W;
  localparam int BYTE_W     = (BYTE_COUNT > 1) ? $clog2(BYTE_COUNT) : 1;
  localparam int LOW_W      = $clog2(GROUP_W);

  localparam int FUNC_W     = 2;
  localparam int VALUE_W    = 32;
  localparam int NEXT_W     = 33;
  localparam int FIRST_W    = 32;
  localparam int SIZE_W     = 13;
  localparam int PROD_W     = 2 * VALUE_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int CNT_W      = $clog2(VALUE_W);

  localparam logic [FIRST_W-1:0] FIRST_RESET = FIRST_W'(2);
  localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(4096);

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_FIRST = 1'b0,
    REG_BLOCK_SIZE  = 1'b1
  } cfg_reg_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INIT    = 2'd0,
    FUNC_FIND    = 2'd1,
    FUNC_SCRATCH = 2'd2
  } func_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FILL,
    S_FIND_RD,
    S_FIND_CHK,
    S_FIND_ENC,
    S_FIND_SUM,
    S_DIV_GO,
    S_DIV_WAIT,
    S_MUL,
    S_MUL_SUB,
    S_SWEEP_CHK,
    S_SC_RD,
    S_SC_CLR,
    S_RESP
  } state_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    word_t             wr_data;
  } mem_req_t;

  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] dividend;
    logic [VALUE_W-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [VALUE_W-1:0] remainder;
  } rem_sts_t;

  // Bits of word w that stand for numbers inside a block of n numbers.
  function automatic word_t live_mask(input logic [ADDR_W-1:0] w,
                                      input logic [SIZE_W-1:0] n);
    logic [IDX_W:0] lo;
    logic [IDX_W:0] span;
    word_t          m;
    lo   = {1'b0, w, {BIT_W{1'b0}}};
    span = (IDX_W + 1)'(n) - lo;
    if ((IDX_W + 1)'(n) <= lo) begin
      m = '0;
    end else if (span >= (IDX_W + 1)'(WORD_BITS)) begin
      m = '1;
    end else begin
      m = ~({WORD_BITS{1'b1}} << span[BIT_W-1:0]);
    end
    return m;
  endfunction

endpackage

>>> rtl/spsv_req_if.sv
// ----------------------------------------------------------------------------
// Sieve request channel
// Valid/ready channel carrying one operation code and its operand.
// ----------------------------------------------------------------------------
interface spsv_req_if;
  logic                         valid;
  logic                         ready;
  logic [spsv_pkg::FUNC_W-1:0]  func;
  logic [spsv_pkg::VALUE_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

>>> rtl/spsv_resp_if.sv
// ----------------------------------------------------------------------------
// Sieve response channel
// Valid/ready channel carrying the found number and the two status flags.
// ----------------------------------------------------------------------------
interface spsv_resp_if;
  logic                        valid;
  logic                        ready;
  logic [spsv_pkg::NEXT_W-1:0] next_value;
  logic                        none_left;
  logic                        range_error;

  modport source (output valid, output next_value, output none_left,
                  output range_error, input ready);
  modport sink   (input valid, input next_value, input none_left,
                  input range_error, output ready);
endinterface

>>> rtl/spsv_mem.sv
// ----------------------------------------------------------------------------
// Sieve word store
// Candidate bit words with one read and one write port and registered read
// data. A per-word written flag makes untouched words read as all ones.
// ----------------------------------------------------------------------------
module spsv_mem (
  input  logic               clk,
  input  logic               rst,
  input  spsv_pkg::mem_req_t req,
  output spsv_pkg::word_t    rdata
);
  import spsv_pkg::*;

  word_t                 store [WORD_COUNT];
  logic [WORD_COUNT-1:0] written;
  word_t                 raw;
  logic                  raw_valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      store[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      raw <= store[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      raw_valid <= 1'b0;
    end else begin
      if (req.wr_en) begin
        written[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        raw_valid <= written[req.rd_addr];
      end
    end
  end

  // After reset every word reads as the full-block pattern, which is all ones.
  assign rdata = raw_valid ? raw : '1;

endmodule

>>> rtl/spsv_rem.sv
// ----------------------------------------------------------------------------
// Sieve remainder unit
// Restoring divider that yields dividend mod divisor, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module spsv_rem (
  input  logic               clk,
  input  logic               rst,
  input  spsv_pkg::rem_req_t req,
  output spsv_pkg::rem_sts_t sts
);
  import spsv_pkg::*;

  logic               busy;
  logic               done;
  logic [CNT_W-1:0]   cnt;
  logic [VALUE_W-1:0] dvd;
  logic [VALUE_W-1:0] dvs;
  logic [VALUE_W:0]   part;
  logic [VALUE_W:0]   shifted;
  logic [VALUE_W:0]   diff;

  assign shifted = {part[VALUE_W-1:0], dvd[VALUE_W-1]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(VALUE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd  <= req.dividend;
      dvs  <= req.divisor;
      part <= '0;
    end else if (busy) begin
      // A borrow out of the top bit means the trial subtract failed.
      part <= diff[VALUE_W] ? shifted : diff;
      dvd  <= {dvd[VALUE_W-2:0], 1'b0};
    end
  end

  assign sts.busy      = busy;
  assign sts.done      = done;
  assign sts.remainder = part[VALUE_W-1:0];

endmodule

>>> rtl/segmented_prime_sieve_block_top.sv
// ----------------------------------------------------------------------------
// Segmented prime sieve block
// Init: one store write per word for 64 words, then the response.
// Find: one store read per word scanned, until a set bit or the block end.
// Scratch: setup, with a wait on the remainder unit for a prime below the block;
// per touched word a read, clears bit by bit and a write. One request at a time.
// Reset is synchronous: registers go to 2 and 4096, all bits read as set.
// ----------------------------------------------------------------------------
module segmented_prime_sieve_block_top (
  input  logic                            clk,
  input  logic                            rst,
  spsv_req_if.sink                        req,
  spsv_resp_if.source                     resp,
  input  logic                            cfg_write,
  input  logic [spsv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spsv_pkg::CFG_DATA_W-1:0] cfg_data
);
  import spsv_pkg::*;

  state_t              state;
  state_t              state_next;
  logic [FIRST_W-1:0]  block_first;
  logic [SIZE_W-1:0]   block_len;
  logic [SIZE_W-1:0]   eff_n;

  logic [FUNC_W-1:0]   func_q;
  logic [VALUE_W-1:0]  val_q;
  logic [NEXT_W-1:0]   off;
  logic [NEXT_W-1:0]   block_end;
  logic                lo_ok;
  logic                hi_ok;

  logic [ADDR_W-1:0]   fill_cnt;
  logic [ADDR_W-1:0]   fw;
  logic [IDX_W:0]      next_lo;
  logic                scan_stop;
  word_t               masked;
  word_t               hit;
  logic [BYTE_W-1:0]   grp_sel;
  logic [BYTE_W-1:0]   grp_idx;
  logic [GROUP_W-1:0]  grp_bits;
  logic [LOW_W-1:0]    low_sel;
  logic [BIT_W-1:0]    word_off;

  logic [PROD_W-1:0]   sq;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   k64;
  logic [IDX_W-1:0]    k;
  logic [IDX_W:0]      k_next;
  logic [SIZE_W-1:0]   step;
  logic                single;
  logic                own_phase;
  logic                fresh;
  word_t               wbuf;
  word_t               src;
  word_t               cleared;
  logic                sweep_stop;
  logic                end_word;

  logic [NEXT_W-1:0]   res_next;
  logic                res_none;
  logic                res_err;
  logic                out_valid;
  logic [NEXT_W-1:0]   out_next;
  logic                out_none;
  logic                out_err;
  logic                can_load;

  word_t               rdata;
  mem_req_t            mem_req;
  rem_req_t            rem_req;
  rem_sts_t            rem_sts;

  spsv_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .req   (mem_req),
    .rdata (rdata)
  );

  spsv_rem u_rem (
    .clk (clk),
    .rst (rst),
    .req (rem_req),
    .sts (rem_sts)
  );

  // Shared address and compare terms.
  assign eff_n     = (32'(block_len) > 32'(SIEVE_BITS)) ? SIZE_W'(SIEVE_BITS) : block_len;
  assign off       = {1'b0, val_q} - {1'b0, block_first};
  assign block_end = {1'b0, block_first} + NEXT_W'(eff_n);
  assign lo_ok     = val_q >= block_first;
  assign hi_ok     = {1'b0, val_q} < block_end;
  assign next_lo   = {1'b0, fw, {BIT_W{1'b0}}} + (IDX_W + 1)'(WORD_BITS);
  assign scan_stop = next_lo >= (IDX_W + 1)'(eff_n);
  assign masked    = rdata & live_mask(fw, eff_n);
  assign sq        = val_q * val_q;

  assign src        = fresh ? rdata : wbuf;
  assign cleared    = src & ~(word_t'(1) << k[BIT_W-1:0]);
  assign k_next     = {1'b0, k} + (IDX_W + 1)'(step);
  assign sweep_stop = single || (k_next >= (IDX_W + 1)'(eff_n));
  assign end_word   = sweep_stop || (k_next[IDX_W:BIT_W] != {1'b0, k[IDX_W-1:BIT_W]});
  assign can_load   = !out_valid || resp.ready;

  always_comb begin
    grp_sel = '0;
    for (int i = BYTE_COUNT - 1; i >= 0; i--) begin
      if (hit[i*GROUP_W +: GROUP_W] != '0) begin
        grp_sel = BYTE_W'(i);
      end
    end
  end

  always_comb begin
    low_sel = '0;
    for (int i = GROUP_W - 1; i >= 0; i--) begin
      if (grp_bits[i]) begin
        low_sel = LOW_W'(i);
      end
    end
  end

  assign word_off = BIT_W'({grp_idx, low_sel});

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        priority case (func_q)
          FUNC_INIT: state_next = S_FILL;
          FUNC_FIND: state_next = (lo_ok && hi_ok) ? S_FIND_RD : S_RESP;
          FUNC_SCRATCH: begin
            if (val_q == '0 || !hi_ok) begin
              state_next = S_RESP;
            end else if (lo_ok) begin
              state_next = S_SC_RD;
            end else begin
              state_next = S_DIV_GO;
            end
          end
          default: state_next = S_RESP;
        endcase
      end
      S_FILL: begin
        if (fill_cnt == ADDR_W'(WORD_COUNT - 1)) begin
          state_next = S_RESP;
        end
      end
      S_FIND_RD: state_next = S_FIND_CHK;
      S_FIND_CHK: begin
        if (masked != '0) begin
          state_next = S_FIND_ENC;
        end else if (scan_stop) begin
          state_next = S_RESP;
        end else begin
          state_next = S_FIND_RD;
        end
      end
      S_FIND_ENC: state_next = S_FIND_SUM;
      S_FIND_SUM: state_next = S_RESP;
      S_DIV_GO:   state_next = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (rem_sts.done) begin
          state_next = S_SWEEP_CHK;
        end
      end
      S_MUL:     state_next = S_MUL_SUB;
      S_MUL_SUB: state_next = S_SWEEP_CHK;
      S_SWEEP_CHK: begin
        state_next = (k64 >= PROD_W'(eff_n)) ? S_RESP : S_SC_RD;
      end
      S_SC_RD: state_next = S_SC_CLR;
      S_SC_CLR: begin
        if (end_word) begin
          if (sweep_stop) begin
            state_next = own_phase ? S_MUL : S_RESP;
          end else begin
            state_next = S_SC_RD;
          end
        end
      end
      S_RESP: begin
        if (can_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs toward the store, the remainder unit and the request channel.
  always_comb begin
    req.ready        = (state == S_IDLE);
    mem_req.rd_en    = (state == S_FIND_RD) || (state == S_SC_RD);
    mem_req.rd_addr  = (state == S_FIND_RD) ? fw : k[IDX_W-1:BIT_W];
    mem_req.wr_en    = (state == S_FILL) || ((state == S_SC_CLR) && end_word);
    mem_req.wr_addr  = (state == S_FILL) ? fill_cnt : k[IDX_W-1:BIT_W];
    mem_req.wr_data  = (state == S_FILL) ? live_mask(fill_cnt, eff_n) : cleared;
    rem_req.start    = (state == S_DIV_GO);
    rem_req.dividend = block_first;
    rem_req.divisor  = val_q;
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      block_first <= FIRST_RESET;
      block_len   <= SIZE_RESET;
    end else begin
      state <= state_next;
      if (state == S_RESP && can_load) begin
        out_valid <= 1'b1;
      end else if (resp.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_BLOCK_FIRST: block_first <= cfg_data[FIRST_W-1:0];
          REG_BLOCK_SIZE:  block_len   <= cfg_data[SIZE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          func_q <= req.func;
          val_q  <= req.value;
        end
      end
      S_DECODE: begin
        res_next  <= '0;
        res_none  <= 1'b0;
        res_err   <= ((func_q == FUNC_FIND) && !(lo_ok && hi_ok)) ||
                     ((func_q == FUNC_SCRATCH) && (val_q == '0));
        fill_cnt  <= '0;
        fw        <= off[IDX_W-1:BIT_W];
        k         <= off[IDX_W-1:0];
        single    <= 1'b1;
        own_phase <= 1'b1;
      end
      S_FILL: fill_cnt <= fill_cnt + 1'b1;
      S_FIND_CHK: begin
        hit <= masked;
        if (masked == '0) begin
          fw <= fw + 1'b1;
          if (scan_stop) begin
            res_next <= block_end;
            res_none <= 1'b1;
          end
        end
      end
      S_FIND_ENC: begin
        grp_idx  <= grp_sel;
        grp_bits <= hit[grp_sel*GROUP_W +: GROUP_W];
      end
      S_FIND_SUM: res_next <= {1'b0, block_first} + NEXT_W'({fw, word_off});
      S_DIV_WAIT: begin
        // First multiple at or above block_first, as an offset into the block.
        if (rem_sts.done) begin
          k64       <= (rem_sts.remainder == '0) ? '0 :
                       PROD_W'(val_q - rem_sts.remainder);
          own_phase <= 1'b0;
        end
      end
      S_MUL: prod <= sq;
      S_MUL_SUB: begin
        k64       <= prod - PROD_W'(block_first);
        own_phase <= 1'b0;
      end
      S_SWEEP_CHK: begin
        k      <= k64[IDX_W-1:0];
        step   <= val_q[SIZE_W-1:0];
        single <= !(val_q <= VALUE_W'(eff_n));
      end
      S_SC_RD: fresh <= 1'b1;
      S_SC_CLR: begin
        fresh <= 1'b0;
        if (!end_word) begin
          wbuf <= cleared;
          k    <= k_next[IDX_W-1:0];
        end else if (!sweep_stop) begin
          k <= k_next[IDX_W-1:0];
        end
      end
      S_RESP: begin
        if (can_load) begin
          out_next <= res_next;
          out_none <= res_none;
          out_err  <= res_err;
        end
      end
      default: ;
    endcase
  end

  assign resp.valid       = out_valid;
  assign resp.next_value  = out_next;
  assign resp.none_left   = out_none;
  assign resp.range_error = out_err;

`ifndef SYNTHESIS
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    resp.valid |-> !(resp.none_left && resp.range_error))
    else $error("none_left and range_error raised together");

  a_err_zero_value: assert property (@(posedge clk) disable iff (rst)
    (resp.valid && resp.range_error) |-> (resp.next_value == '0))
    else $error("range_error response carries a nonzero value");

  a_sweep_in_block: assert property (@(posedge clk) disable iff (rst)
    (state == S_SC_CLR) |-> ((IDX_W + 1)'(k) < (IDX_W + 1)'(eff_n)))
    else $error("scratch clears a bit outside the block");

  a_scan_in_block: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIND_CHK) |-> ({1'b0, fw, {BIT_W{1'b0}}} < (IDX_W + 1)'(eff_n)))
    else $error("find scans a word beyond the block");

  a_rem_done_waited: assert property (@(posedge clk) disable iff (rst)
    rem_sts.done |-> (state == S_DIV_WAIT))
    else $error("remainder finished while nobody waits for it");
`endif

endmodule

>>> tb/spsv_sieve_checker.sv
// ----------------------------------------------------------------------------
// Sieve block scoreboard
// Watches the request, response and register write ports of the sieve block,
// keeps its own copy of the candidate bits and block registers, works out the
// answer to each accepted request and compares it with the block's response.
// ----------------------------------------------------------------------------
module spsv_sieve_checker (
  input  logic                            clk,
  input  logic                            rst,
  spsv_req_if                             req,
  spsv_resp_if                            resp,
  input  logic                            cfg_write,
  input  logic [spsv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spsv_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              open_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import spsv_pkg::*;

  typedef struct packed {
    logic [NEXT_W-1:0] next_value;
    logic              none_left;
    logic              range_error;
  } sieve_answer_t;

  word_t               candidate_words [WORD_COUNT];
  logic [FIRST_W-1:0]  first_num;
  logic [SIZE_W-1:0]   size_reg;
  sieve_answer_t       pending_answers [$];
  int                  mismatches = 0;
  int                  answers_seen = 0;

  function automatic logic [63:0] eff_count();
    return (size_reg > SIEVE_BITS) ? 64'(SIEVE_BITS) : 64'(size_reg);
  endfunction

  // Bits of word w that stand for numbers inside a block of n numbers.
  function automatic word_t live_bits(input int w, input logic [63:0] n);
    logic [63:0] lo;
    lo = 64'(w) * WORD_BITS;
    if (lo >= n) return '0;
    if (n - lo >= WORD_BITS) return '1;
    return {WORD_BITS{1'b1}} >> (WORD_BITS - (n - lo));
  endfunction

  task automatic refill_words(input logic [63:0] n);
    for (int w = 0; w < WORD_COUNT; w++) begin
      candidate_words[w] = live_bits(w, n);
    end
  endtask

  task automatic clear_candidate(input logic [63:0] k);
    if (k / WORD_BITS < WORD_COUNT) begin
      candidate_words[k / WORD_BITS][k % WORD_BITS] = 1'b0;
    end
  endtask

  // Applies one request to the local sieve copy and returns its answer.
  task automatic apply_sieve_op(input logic [FUNC_W-1:0] op,
                                input logic [VALUE_W-1:0] val,
                                output sieve_answer_t ans);
    logic [63:0] n;
    logic [63:0] v;
    logic [63:0] base;
    logic [63:0] stop;
    logic [63:0] k;
    word_t       bits;
    int          lowest;
    bit          found;
    n    = eff_count();
    v    = 64'(val);
    base = 64'(first_num);
    stop = base + n;
    ans  = '0;
    case (op)
      FUNC_INIT: begin
        refill_words(n);
      end
      FUNC_FIND: begin
        if (v < base || v >= stop) begin
          ans.range_error = 1'b1;
        end else begin
          found = 1'b0;
          for (int w = int'((v - base) / WORD_BITS); w < WORD_COUNT && !found; w++) begin
            bits = candidate_words[w] & live_bits(w, n);
            if (bits != '0) begin
              lowest = 0;
              for (int b = WORD_BITS - 1; b >= 0; b--) begin
                if (bits[b]) lowest = b;
              end
              ans.next_value = NEXT_W'(base + 64'(w) * WORD_BITS + 64'(lowest));
              found = 1'b1;
            end
          end
          if (!found) begin
            ans.next_value = NEXT_W'(stop);
            ans.none_left  = 1'b1;
          end
        end
      end
      FUNC_SCRATCH: begin
        if (v == 0) begin
          ans.range_error = 1'b1;
        end else if (v < stop) begin
          // A prime inside the block drops its own bit and sweeps from its
          // square; one below the block sweeps from its first multiple there.
          if (v >= base) begin
            clear_candidate(v - base);
            k = v * v - base;
          end else begin
            k = v * ((base + v - 1) / v) - base;
          end
          if (v <= n) begin
            while (k < n) begin
              clear_candidate(k);
              k = k + v;
            end
          end else if (k < n) begin
            clear_candidate(k);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [NEXT_W-1:0] got,
                                 input logic [NEXT_W-1:0] want);
    $display("%0t ns: response %0d, %s: got 0x%0h, expected 0x%0h",
             $time, answers_seen, what, got, want);
    mismatches++;
  endtask

  // Every port is driven with nonblocking assignments, so the values seen
  // here are the ones sampled at this edge.
  always @(posedge clk) begin : watch
    sieve_answer_t want;
    if (rst) begin
      first_num = FIRST_RESET;
      size_reg  = SIZE_RESET;
      refill_words(eff_count());
      pending_answers.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_BLOCK_FIRST: first_num = cfg_data[FIRST_W-1:0];
          REG_BLOCK_SIZE:  size_reg  = cfg_data[SIZE_W-1:0];
          default: begin
          end
        endcase
      end
      if (resp.valid && resp.ready) begin
        answers_seen++;
        if (pending_answers.size() == 0) begin
          report_mismatch("response with no request outstanding", resp.next_value, '0);
        end else begin
          want = pending_answers.pop_front();
          if (resp.next_value !== want.next_value)
            report_mismatch("next_value", resp.next_value, want.next_value);
          if (resp.none_left !== want.none_left)
            report_mismatch("none_left", NEXT_W'(resp.none_left), NEXT_W'(want.none_left));
          if (resp.range_error !== want.range_error)
            report_mismatch("range_error", NEXT_W'(resp.range_error),
                            NEXT_W'(want.range_error));
        end
      end
      if (req.valid && req.ready) begin
        apply_sieve_op(req.func, req.value, want);
        pending_answers.push_back(want);
      end
    end
    open_count <= pending_answers.size();
    fail_count <= mismatches;
  end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// Sieve block testbench
// Drives directed and random sieve requests and block settings into the
// segmented sieve block with random gaps and stalls on both channels, and
// leaves prediction and comparison to the scoreboard beside it.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import spsv_pkg::*;

  // Code 3 has no operation assigned; the block must answer it with zeros.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam int     RANDOM_ITEMS = 850;
  localparam int     LONG_HOLD    = 400;
  localparam int     MAX_PRIME    = 97;
  localparam longint CYCLE_LIMIT  = 16_000_000;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int     fail_count;
  int     open_count;
  int     req_max_gap = 3;
  int     resp_max_gap = 3;
  int     hold_asks = 0;
  int     sent_count = 0;
  int     settings_used = 0;
  int     op_count [4] = '{0, 0, 0, 0};
  longint cycles = 0;

  spsv_req_if  req_ch ();
  spsv_resp_if resp_ch ();

  segmented_prime_sieve_block_top uut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .resp      (resp_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  spsv_sieve_checker sieve_watch (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .resp       (resp_ch),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .open_count (open_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d responses outstanding.", open_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic offer(input logic [FUNC_W-1:0] op, input logic [VALUE_W-1:0] val);
    int gap;
    gap = $urandom_range(0, req_max_gap);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.func  <= op;
    req_ch.value <= val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    op_count[op]++;
    sent_count++;
  endtask

  // Stops offering and waits until every request has been answered.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Writes both block registers on back-to-back cycles; call only when idle.
  task automatic set_block(input logic [FIRST_W-1:0] base, input logic [SIZE_W-1:0] size);
    cfg_write <= 1'b1;
    cfg_index <= REG_BLOCK_FIRST;
    cfg_data  <= CFG_DATA_W'(base);
    @(posedge clk);
    cfg_index <= REG_BLOCK_SIZE;
    cfg_data  <= CFG_DATA_W'(size);
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  initial begin : receiver
    int gap;
    int holds_done;
    holds_done    = 0;
    resp_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_asks != holds_done) begin
        holds_done++;
        gap = LONG_HOLD;
      end else begin
        gap = $urandom_range(0, resp_max_gap);
      end
      if (gap != 0) begin
        resp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      resp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!resp_ch.valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [FIRST_W-1:0] base;
    logic [SIZE_W-1:0]  size;
    longint             n;
    longint             stop;
    int                 target;
    int                 pass_no;
    int                 extra;
    bit                 composite;
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    req_ch.valid = 1'b0;
    req_ch.func  = '0;
    req_ch.value = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset state: block of 4096 numbers from 2, every bit set.
    offer(FUNC_FIND, 32'd2);
    offer(FUNC_SCRATCH, 32'd2);
    offer(FUNC_FIND, 32'd2);
    offer(FUNC_FIND, 32'd4097);
    offer(FUNC_FIND, 32'd4098);
    offer(FUNC_FIND, 32'd1);
    offer(FUNC_SCRATCH, 32'd0);
    offer(FUNC_SCRATCH, 32'd4098);
    offer(FUNC_UNUSED, 32'hFFFF_FFFF);
    offer(FUNC_FIND, 32'hFFFF_FFFF);
    offer(FUNC_SCRATCH, 32'hFFFF_FFFF);
    drain();

    // Top of the number range with an oversized block: results need bit 32.
    set_block(32'hFFFF_FFFF, 13'd8191);
    offer(FUNC_INIT, 32'h0);
    offer(FUNC_FIND, 32'hFFFF_FFFF);
    offer(FUNC_SCRATCH, 32'd2);
    offer(FUNC_SCRATCH, 32'd5000);
    offer(FUNC_SCRATCH, 32'hFFFF_FFFF);
    offer(FUNC_FIND, 32'hFFFF_FFFF);
    drain();

    set_block(32'd0, 13'd0);
    offer(FUNC_FIND, 32'd0);
    offer(FUNC_SCRATCH, 32'd3);
    drain();

    // Scratching one wipes everything but the first number.
    set_block(32'd0, 13'd4096);
    offer(FUNC_INIT, 32'h5555_5555);
    offer(FUNC_SCRATCH, 32'd1);
    offer(FUNC_FIND, 32'd1);
    offer(FUNC_FIND, 32'd64);
    drain();

    // Growing the block without a fresh init leaves the new part empty.
    set_block(32'd100, 13'd100);
    offer(FUNC_INIT, 32'hAAAA_AAAA);
    drain();
    set_block(32'd100, 13'd200);
    offer(FUNC_FIND, 32'd250);
    offer(FUNC_FIND, 32'd120);
    drain();

    target  = sent_count + RANDOM_ITEMS;
    pass_no = 0;
    while (sent_count < target) begin
      pass_no++;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: base = $urandom_range(0, 200);
        4, 5:       base = $urandom_range(0, 1 << 20);
        6:          base = 32'hFFFF_FFFF - $urandom_range(0, 5000);
        default:    base = $urandom();
      endcase
      case ($urandom_range(0, 19))
        0:       size = '0;
        1, 2:    size = 13'd4096;
        3:       size = SIZE_W'($urandom_range(4097, 8191));
        default: size = SIZE_W'($urandom_range(1, 512));
      endcase
      n    = (size > SIEVE_BITS) ? longint'(SIEVE_BITS) : longint'(size);
      stop = longint'(base) + n;

      drain();
      set_block(base, size);
      case ($urandom_range(0, 2))
        0:       req_max_gap = 0;
        1:       req_max_gap = 3;
        default: req_max_gap = 18;
      endcase
      case ($urandom_range(0, 2))
        0:       resp_max_gap <= 0;
        1:       resp_max_gap <= 3;
        default: resp_max_gap <= 18;
      endcase
      if (pass_no == 2 || pass_no == 9) hold_asks <= hold_asks + 1;

      // A proper segment pass: fill, then strike out the small primes.
      offer(FUNC_INIT, $urandom());
      for (int p = 2; p <= MAX_PRIME && longint'(p) * p < stop; p++) begin
        composite = 1'b0;
        for (int d = 2; d * d <= p; d++) begin
          if (p % d == 0) composite = 1'b1;
        end
        if (!composite) offer(FUNC_SCRATCH, p);
      end

      extra = $urandom_range(6, 18);
      repeat (extra) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4:
            offer(FUNC_FIND, base + $urandom_range(0, (n > 0) ? int'(n) - 1 : 0));
          5:       offer(FUNC_SCRATCH, base + $urandom_range(0, int'(n)));
          6:       offer(FUNC_SCRATCH, $urandom_range(0, 300));
          7:       offer(FUNC_FIND, $urandom_range(0, 1) ? base - 1 : base + int'(n));
          default: offer(FUNC_W'($urandom_range(0, 3)), $urandom());
        endcase
      end
    end

    drain();
    repeat (40) @(posedge clk);
    $display("Covered %0d requests: %0d init, %0d find, %0d scratch, %0d unassigned code.",
             sent_count, op_count[FUNC_INIT], op_count[FUNC_FIND],
             op_count[FUNC_SCRATCH], op_count[FUNC_UNUSED]);
    $display("Block settings applied: %0d, long response stalls: %0d.",
             settings_used, hold_asks);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/spsv_pkg.sv
rtl/spsv_req_if.sv
rtl/spsv_resp_if.sv
rtl/spsv_mem.sv
rtl/spsv_rem.sv
rtl/segmented_prime_sieve_block_top.sv
tb/spsv_sieve_checker.sv
tb/tb.sv
